// ----- design/syndrome_matrix_vector_accumulate_unit_defines.svh -----
// ----------------------------------------------------------------------------
// syndrome accumulate unit assertion macros
// shared concurrent assertion forms for the syndrome accumulate unit
// ----------------------------------------------------------------------------
`ifndef SYNDROME_MATRIX_VECTOR_ACCUMULATE_UNIT_DEFINES_SVH
`define SYNDROME_MATRIX_VECTOR_ACCUMULATE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SMVA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SMVA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/smva_pkg.sv -----
// ----------------------------------------------------------------------------
// smva_pkg
// item types and opcodes of the syndrome accumulate unit
// ----------------------------------------------------------------------------
package smva_pkg;

   // width of one key word and one error word
   localparam int WORD_BITS = 32;

   // request opcodes
   typedef enum logic [1:0] {
      OP_SEED  = 2'd0,
      OP_ACCUM = 2'd1,
      OP_READ  = 2'd2
   } opcode_type;

   // request item
   typedef struct packed {
      logic [1:0]           opcode;
      logic [7:0]           byte_index;
      logic [7:0]           seed_byte;
      logic [10:0]          row;
      logic [WORD_BITS-1:0] key_word;
      logic [WORD_BITS-1:0] error_word;
   } req_item_type;

   // response item
   typedef struct packed {
      logic [7:0] syndrome_byte;
      logic [7:0] out_index;
   } rsp_item_type;

endpackage

// ----- design/syndrome_matrix_vector_accumulate_unit.sv -----
// A read's item is registered in the access stage, then in the result buffer.
// Throughput: one item per cycle while fewer than two results are waiting or
// in flight; any item, whatever its opcode, is held back otherwise.
// Each accumulate is one read-modify-write of the syndrome RAM (seeds write,
// reads read), with a one-entry forward path for back-to-back same-byte writes.
// Reset clears only control state; RAM contents are undefined until seeded.
// ----------------------------------------------------------------------------
// syndrome_matrix_vector_accumulate_unit
// niederreiter syndrome accumulator over GF(2), one syndrome byte per RAM entry
// ----------------------------------------------------------------------------
`include "syndrome_matrix_vector_accumulate_unit_defines.svh"

module syndrome_matrix_vector_accumulate_unit #(
   parameter int ROWS = 1664
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  smva_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smva_pkg::rsp_item_type rsp_item
);

   import smva_pkg::*;

   localparam int STORE_BYTES = (ROWS + 7) / 8;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int IDX_W       = (ADDR_W > 8) ? ADDR_W : 8;
   localparam logic [12:0] STORE_BYTES_C = 13'(STORE_BYTES);
   localparam logic [12:0] ROWS_C        = 13'(ROWS);

   // request side
   logic              req_fire;
   logic              op_seed;
   logic              op_accum;
   logic              op_read;
   logic              idx_ok;
   logic              row_ok;
   logic [IDX_W-1:0]  idx_wide;
   logic [IDX_W-1:0]  row_wide;
   logic [ADDR_W-1:0] rd_addr;
   logic              word_parity;
   logic [7:0]        acc_mask;

   // access stage
   logic              s1_valid_ff, s1_valid_in;
   logic [1:0]        s1_op_ff;
   logic              s1_ok_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [7:0]        s1_mask_ff;
   logic [7:0]        s1_seed_ff;
   logic [7:0]        s1_index_ff;
   logic [7:0]        ram_rd_data;
   logic [7:0]        cur_byte;
   logic              wr_en;
   logic [7:0]        wr_data;
   logic              push;
   rsp_item_type      push_item;

   // forward path for the write of the previous item
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [7:0]        fwd_data_ff;

   // two-entry result buffer
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;
   logic              skid_valid_ff, skid_valid_in;
   rsp_item_type      skid_item_ff, skid_item_in;
   logic              pop;
   logic [1:0]        pending;

   // accept unless two results could collide in the buffer
   assign pending   = 2'(rsp_valid_ff) + 2'(skid_valid_ff)
                    + 2'(s1_valid_ff && (s1_op_ff == OP_READ));
   assign req_stall = (pending >= 2'd2);
   assign req_fire  = req_valid && !req_stall;

   // decode and address
   assign op_seed  = (req_item.opcode == OP_SEED);
   assign op_accum = (req_item.opcode == OP_ACCUM);
   assign op_read  = (req_item.opcode == OP_READ);
   assign idx_ok   = ({5'b0, req_item.byte_index} < STORE_BYTES_C);
   assign row_ok   = ({2'b0, req_item.row} < ROWS_C);
   assign idx_wide = IDX_W'(req_item.byte_index);
   assign row_wide = IDX_W'(req_item.row[10:3]);
   assign rd_addr  = op_accum ? row_wide[ADDR_W-1:0] : idx_wide[ADDR_W-1:0];

   // parity of the masked key word becomes one bit of the row's byte
   assign word_parity = ^(req_item.key_word & req_item.error_word);
   assign acc_mask    = word_parity ? (8'd1 << req_item.row[2:0]) : 8'd0;

   assign s1_valid_in = req_fire;

   // access stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= wr_en;
      end
   end

   // access stage payload
   always_ff @(posedge clock) begin
      s1_op_ff    <= req_item.opcode;
      s1_ok_ff    <= op_accum ? row_ok : (idx_ok && (op_seed || op_read));
      s1_addr_ff  <= rd_addr;
      s1_mask_ff  <= acc_mask;
      s1_seed_ff  <= req_item.seed_byte;
      s1_index_ff <= req_item.byte_index;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= wr_data;
   end

   smva_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_synd_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // modify and write back, forwarding the previous write
   always_comb begin
      cur_byte = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rd_data;
      wr_en    = s1_valid_ff && s1_ok_ff
               && ((s1_op_ff == OP_SEED) || (s1_op_ff == OP_ACCUM));
      wr_data  = (s1_op_ff == OP_SEED) ? s1_seed_ff : (cur_byte ^ s1_mask_ff);
      push     = s1_valid_ff && (s1_op_ff == OP_READ);
      push_item.syndrome_byte = s1_ok_ff ? cur_byte : 8'd0;
      push_item.out_index     = s1_index_ff;
   end

   // result buffer: head register plus skid entry
   assign pop = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_item_in   = rsp_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_item_in   = skid_item_ff;
            skid_valid_in = push;
            skid_item_in  = push_item;
         end else begin
            rsp_valid_in  = push;
            rsp_item_in   = push_item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff  <= rsp_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // checks
   `SMVA_ASSERT_SAME(a_skid_behind_head, clock, reset, skid_valid_ff, rsp_valid_ff, "skid without head")
   `SMVA_ASSERT_SAME(a_no_overflow, clock, reset, push && skid_valid_ff, pop, "buffer overflow")
   `SMVA_ASSERT_NEXT(a_item_reaches_access, clock, reset, req_fire, s1_valid_ff, "item lost")
   `SMVA_ASSERT_NEXT(a_fwd_tracks_write, clock, reset, wr_en, fwd_valid_ff && (fwd_data_ff == $past(wr_data)), "fwd miss")

endmodule

// ----- design/smva_ram.sv -----
// ----------------------------------------------------------------------------
// smva_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module smva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 208
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
